// ===== design/tlkoi_pkg.sv =====
// Shared types and constants for the three-level key offset index.
package tlkoi_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int LOCAL_W = 16;
    localparam int RUN_W   = 32;
    localparam int LEN_W   = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_LOOK,
        ST_LOOK_SUM
    } back_state_t;

endpackage

// ===== design/tlkoi_ram.sv =====
// Generic single-port RAM with registered read.
module tlkoi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/tlkoi_front.sv =====
// Two-entry item queue in front of the table walker.
module tlkoi_front #(
    parameter int KEY_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     in_func,
    input  logic [KEY_BITS-1:0]            in_key,
    input  logic [tlkoi_pkg::LEN_W-1:0]    in_length,
    output logic                           q_valid,
    input  logic                           q_pop,
    output logic [1:0]                     q_func,
    output logic [KEY_BITS-1:0]            q_key,
    output logic [tlkoi_pkg::LEN_W-1:0]    q_length
);
    localparam int IW = 2 + KEY_BITS + tlkoi_pkg::LEN_W;
    logic [IW-1:0] slot_reg [2];
    logic [1:0]    cnt_reg;
    logic          rd_reg, wr_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && (in_func != tlkoi_pkg::FUNC_UNUSED);
    assign pop  = q_pop && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_func, q_key, q_length} = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= {in_func, in_key, in_length};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== design/tlkoi_back.sv =====
// Table walker: key writes, finish, lookups.
module tlkoi_back #(
    parameter int KEY_BITS    = 16,
    parameter int BLOCK_SHIFT = 6,
    parameter int SUPER_SHIFT = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  logic [1:0]                   q_func,
    input  logic [KEY_BITS-1:0]          q_key,
    input  logic [tlkoi_pkg::LEN_W-1:0]  q_length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tlkoi_pkg::RUN_W-1:0]  offset
);
    localparam int BB = KEY_BITS - BLOCK_SHIFT;
    localparam int SB = (KEY_BITS > SUPER_SHIFT) ? KEY_BITS - SUPER_SHIFT : 1;
    localparam int BD = 1 << BB;
    localparam int SD = 1 << SB;
    localparam int LD = 1 << KEY_BITS;
    localparam int LW = tlkoi_pkg::LOCAL_W;
    localparam int RW = tlkoi_pkg::RUN_W;

    tlkoi_pkg::back_state_t st_reg, st_next;

    logic [KEY_BITS-1:0] prev_reg, prev_next, k_reg, k_next, tgt_reg, tgt_next;
    logic [LW-1:0]       lrun_reg, lrun_next;
    logic [RW-1:0]       brun_reg, brun_next, srun_reg, srun_next;
    // fill mark: highest key written; entries above it read as zero
    logic [KEY_BITS-1:0] hw_reg, hw_next;
    logic [tlkoi_pkg::LEN_W-1:0] len_reg, len_next;
    logic                fin_reg, fin_next;
    logic [RW-1:0]       out_reg, out_next;
    logic                ov_reg, ov_next;

    logic                l_we, b_we, s_we;
    logic [KEY_BITS-1:0] l_addr;
    logic [BB-1:0]       b_addr;
    logic [SB-1:0]       s_addr;
    logic [LW-1:0]       l_wd, l_rd;
    logic [RW-1:0]       b_wd, b_rd, s_wd, s_rd;
    logic [KEY_BITS-1:0] lk_reg;
    logic                l_ok, b_ok, s_ok;

    tlkoi_ram #(.WIDTH(LW), .DEPTH(LD)) u_local (.clk(clk), .we(l_we), .addr(l_addr),
        .wdata(l_wd), .rdata(l_rd));
    tlkoi_ram #(.WIDTH(RW), .DEPTH(BD)) u_block (.clk(clk), .we(b_we), .addr(b_addr),
        .wdata(b_wd), .rdata(b_rd));
    tlkoi_ram #(.WIDTH(RW), .DEPTH(SD)) u_super (.clk(clk), .we(s_we), .addr(s_addr),
        .wdata(s_wd), .rdata(s_rd));

    assign out_valid = ov_reg;
    assign offset    = out_reg;

    // key 0 and the first block/superblock entries are never written
    assign l_ok = (lk_reg != '0) && (lk_reg <= hw_reg);
    assign b_ok = ((lk_reg >> BLOCK_SHIFT) != '0)
               && ((lk_reg >> BLOCK_SHIFT) <= (hw_reg >> BLOCK_SHIFT));
    assign s_ok = ((lk_reg >> SUPER_SHIFT) != '0)
               && ((lk_reg >> SUPER_SHIFT) <= (hw_reg >> SUPER_SHIFT));

    // previous key, boundary flags and run values to write for the walker key
    logic [KEY_BITS-1:0] last_key;
    logic                nb, ns;
    logic [LW-1:0]       lr_w;
    logic [RW-1:0]       br_w, sr_w;

    always_comb
    begin
        st_next   = st_reg;
        prev_next = prev_reg;
        k_next    = k_reg;
        tgt_next  = tgt_reg;
        lrun_next = lrun_reg;
        brun_next = brun_reg;
        srun_next = srun_reg;
        hw_next   = hw_reg;
        len_next  = len_reg;
        fin_next  = fin_reg;
        out_next  = out_reg;
        ov_next   = ov_reg && !out_ready;
        q_pop     = 1'b0;
        l_we = 1'b0; b_we = 1'b0; s_we = 1'b0;
        l_addr = q_key;
        b_addr = BB'(q_key >> BLOCK_SHIFT);
        s_addr = SB'(q_key >> SUPER_SHIFT);
        last_key = k_reg - 1'b1;
        nb = (last_key >> BLOCK_SHIFT) != (k_reg >> BLOCK_SHIFT);
        ns = (last_key >> SUPER_SHIFT) != (k_reg >> SUPER_SHIFT);
        lr_w = nb ? '0 : lrun_reg;
        br_w = nb ? brun_reg + RW'(lrun_reg) : brun_reg;
        sr_w = ns ? srun_reg + br_w : srun_reg;
        if (ns)
        begin
            br_w = '0;
        end
        l_wd = lr_w;
        b_wd = br_w;
        s_wd = sr_w;
        case (st_reg)
            tlkoi_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_func)
                        tlkoi_pkg::FUNC_ADD:
                        begin
                            q_pop = 1'b1;
                            if (q_key == prev_reg)
                            begin
                                lrun_next = lrun_reg + LW'(q_length);
                            end
                            else if (q_key > prev_reg)
                            begin
                                k_next   = prev_reg + 1'b1;
                                tgt_next = q_key;
                                len_next = q_length;
                                fin_next = 1'b0;
                                st_next  = tlkoi_pkg::ST_WALK;
                            end
                        end
                        tlkoi_pkg::FUNC_FINISH:
                        begin
                            q_pop = 1'b1;
                            if (prev_reg != {KEY_BITS{1'b1}})
                            begin
                                k_next   = prev_reg + 1'b1;
                                tgt_next = prev_reg + 1'b1;
                                fin_next = 1'b1;
                                st_next  = tlkoi_pkg::ST_WALK;
                            end
                        end
                        tlkoi_pkg::FUNC_LOOKUP:
                        begin
                            if (!ov_reg)
                            begin
                                q_pop   = 1'b1;
                                st_next = tlkoi_pkg::ST_LOOK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            tlkoi_pkg::ST_WALK:
            begin
                l_addr = k_reg;
                b_addr = BB'(k_reg >> BLOCK_SHIFT);
                s_addr = SB'(k_reg >> SUPER_SHIFT);
                l_we   = 1'b1;
                b_we   = nb;
                s_we   = ns;
                // walks start at the fill mark after a finish and right above it
                // otherwise, so the mark always holds the last key written
                hw_next   = k_reg;
                lrun_next = lr_w;
                brun_next = br_w;
                srun_next = sr_w;
                k_next    = k_reg + 1'b1;
                if (k_reg == tgt_reg)
                begin
                    st_next = tlkoi_pkg::ST_IDLE;
                    if (!fin_reg)
                    begin
                        prev_next = tgt_reg;
                        lrun_next = lr_w + LW'(len_reg);
                    end
                end
            end
            tlkoi_pkg::ST_LOOK:
            begin
                st_next = tlkoi_pkg::ST_LOOK_SUM;
            end
            tlkoi_pkg::ST_LOOK_SUM:
            begin
                out_next = (l_ok ? RW'(l_rd) : '0)
                         + (b_ok ? b_rd : '0)
                         + (s_ok ? s_rd : '0);
                ov_next = 1'b1;
                st_next = tlkoi_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = tlkoi_pkg::ST_IDLE;
            end
        endcase
        if (st_reg == tlkoi_pkg::ST_LOOK || st_reg == tlkoi_pkg::ST_LOOK_SUM)
        begin
            l_addr = lk_reg;
            b_addr = BB'(lk_reg >> BLOCK_SHIFT);
            s_addr = SB'(lk_reg >> SUPER_SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == tlkoi_pkg::ST_IDLE)
        begin
            lk_reg <= q_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= tlkoi_pkg::ST_IDLE;
            prev_reg <= '0;
            k_reg    <= '0;
            tgt_reg  <= '0;
            lrun_reg <= '0;
            brun_reg <= '0;
            srun_reg <= '0;
            hw_reg   <= '0;
            len_reg  <= '0;
            fin_reg  <= 1'b0;
            out_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            prev_reg <= prev_next;
            k_reg    <= k_next;
            tgt_reg  <= tgt_next;
            lrun_reg <= lrun_next;
            brun_reg <= brun_next;
            srun_reg <= srun_next;
            hw_reg   <= hw_next;
            len_reg  <= len_next;
            fin_reg  <= fin_next;
            out_reg  <= out_next;
            ov_reg   <= ov_next;
        end
    end
endmodule

// ===== design/three_level_key_offset_index_top.sv =====
// Top level of the three-level key offset index.
// A lookup passes ST_LOOK and ST_LOOK_SUM after its pop, then the sum is registered.
// An add of a higher key writes each key after the previous key up to it (gap fill); a
// finish writes the key after the previous key unless that is the top key. A waiting
// result holds off the next lookup; a two-entry queue keeps taking items meanwhile.
// Reset (rst_n low, async) clears running offsets and the fill mark; tables read as zero.
module three_level_key_offset_index_top #(
    parameter int KEY_BITS    = 16,
    parameter int BLOCK_SHIFT = 6,
    parameter int SUPER_SHIFT = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [tlkoi_pkg::LEN_W-1:0]  length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tlkoi_pkg::RUN_W-1:0]  offset
);
    logic                        q_valid, q_pop;
    logic [1:0]                  q_func;
    logic [KEY_BITS-1:0]         q_key;
    logic [tlkoi_pkg::LEN_W-1:0] q_length;

    // front: accept items into the queue
    tlkoi_front #(.KEY_BITS(KEY_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_func(func), .in_key(key), .in_length(length),
        .q_valid(q_valid), .q_pop(q_pop),
        .q_func(q_func), .q_key(q_key), .q_length(q_length)
    );

    // back: walk and update the tables, serve lookups
    tlkoi_back #(.KEY_BITS(KEY_BITS), .BLOCK_SHIFT(BLOCK_SHIFT),
                 .SUPER_SHIFT(SUPER_SHIFT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop),
        .q_func(q_func), .q_key(q_key), .q_length(q_length),
        .out_valid(out_valid), .out_ready(out_ready), .offset(offset)
    );
endmodule

// ===== design/tlkoi_checker.sv =====
// Port-level checker for the key offset index, bound to the top level.
module tlkoi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] offset
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(offset))
        else $error("result dropped while stalled");
    a_reset_out: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result during reset");
    a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input item withdrawn before accept");
endmodule

bind three_level_key_offset_index_top tlkoi_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .offset(offset)
);
